// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge of clk, skipped while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same check, not disabled by reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/nsls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsls_pkg: shared types and constants
// Phase codes, event codes, register indexes, config and result bundles.
// ----------------------------------------------------------------------------
package nsls_pkg;

   localparam int unsigned LINES       = 256;
   localparam int unsigned ROW_WORDS   = 32;
   localparam int unsigned BURST_WORDS = 2;
   localparam bit          COLOR_ENABLE = 1'b1;

   localparam logic [7:0] LINE_MAX        = 8'(LINES - 1);
   localparam logic [7:0] ROW_WORD_COUNT  = 8'(ROW_WORDS);
   localparam logic [7:0] BURST_WORD_COUNT = 8'(BURST_WORDS);
   localparam logic [7:0] REPEAT_MASK     = 8'hFF;

   localparam logic [1:0] MODE_UPDATE = 2'd0;
   localparam logic [1:0] MODE_LINE   = 2'd1;
   localparam logic [1:0] MODE_BURST  = 2'd2;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_EQUALIZE_WIDTH    = 3'd0,
      CSR_VSYNC_WIDTH       = 3'd1,
      CSR_HSYNC_WIDTH       = 3'd2,
      CSR_EQUALIZE_PERIOD   = 3'd3,
      CSR_LINE_PERIOD       = 3'd4,
      CSR_EQUALIZE_REPEAT   = 3'd5,
      CSR_PRE_ACTIVE_REPEAT = 3'd6,
      CSR_ACTIVE_REPEAT     = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_EQ0  = 3'd0,
      PH_VERT = 3'd1,
      PH_EQ1  = 3'd2,
      PH_PRE  = 3'd3,
      PH_ACT  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [15:0] equalize_width;
      logic [15:0] vsync_width;
      logic [15:0] hsync_width;
      logic [15:0] equalize_period;
      logic [15:0] line_period;
      logic [7:0]  equalize_repeat;
      logic [7:0]  pre_active_repeat;
      logic [7:0]  active_repeat;
   } cfg_type;

   typedef struct packed {
      logic [15:0] sync_width;
      logic [15:0] period;
      logic [7:0]  repeat_count;
      logic        draw_lock;
      logic        frame_tick;
      logic        serial_restart;
      logic        fetch_start;
      logic        fetch_from_burst;
      logic [7:0]  fetch_line;
      logic [7:0]  fetch_words;
   } result_type;

endpackage

// File: hw/rtl/nsls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsls_if: channel interfaces
// Event, result and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nsls_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       frame_count_enable;
   modport source (output valid, mode, frame_count_enable, input ready);
   modport sink   (input valid, mode, frame_count_enable, output ready);
endinterface

interface nsls_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sync_width;
   logic [15:0] period;
   logic [7:0]  repeat_count;
   logic        draw_lock;
   logic        frame_tick;
   logic        serial_restart;
   logic        fetch_start;
   logic        fetch_from_burst;
   logic [7:0]  fetch_line;
   logic [7:0]  fetch_words;
   modport source (output valid, sync_width, period, repeat_count, draw_lock,
                   frame_tick, serial_restart, fetch_start, fetch_from_burst,
                   fetch_line, fetch_words, input ready);
   modport sink   (input valid, sync_width, period, repeat_count, draw_lock,
                   frame_tick, serial_restart, fetch_start, fetch_from_burst,
                   fetch_line, fetch_words, output ready);
endinterface

interface nsls_csr_if;
   logic                                valid;
   logic                                ready;
   logic [nsls_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [nsls_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/nsls_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsls_csr: configuration registers
// Timing widths, periods and repeat counts, written one beat at a time.
// ----------------------------------------------------------------------------
module nsls_csr (
   input  logic              clock,
   input  logic              reset,
   nsls_csr_if.sink          csr_chan,
   output nsls_pkg::cfg_type cfg
);

   nsls_pkg::cfg_type cfg_ff;
   nsls_pkg::cfg_type cfg_in;
   logic              write;

   assign csr_chan.ready = 1'b1;
   assign write = csr_chan.valid & csr_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (nsls_pkg::csr_index_type'(csr_chan.index))
            nsls_pkg::CSR_EQUALIZE_WIDTH:    cfg_in.equalize_width = csr_chan.data;
            nsls_pkg::CSR_VSYNC_WIDTH:       cfg_in.vsync_width = csr_chan.data;
            nsls_pkg::CSR_HSYNC_WIDTH:       cfg_in.hsync_width = csr_chan.data;
            nsls_pkg::CSR_EQUALIZE_PERIOD:   cfg_in.equalize_period = csr_chan.data;
            nsls_pkg::CSR_LINE_PERIOD:       cfg_in.line_period = csr_chan.data;
            nsls_pkg::CSR_EQUALIZE_REPEAT:   cfg_in.equalize_repeat = csr_chan.data[7:0];
            nsls_pkg::CSR_PRE_ACTIVE_REPEAT: cfg_in.pre_active_repeat = csr_chan.data[7:0];
            nsls_pkg::CSR_ACTIVE_REPEAT:     cfg_in.active_repeat = csr_chan.data[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/nsls_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsls_core: frame sequence and fetch control
// Holds phase, row and shadow state; computes one result per stepped event.
// ----------------------------------------------------------------------------
module nsls_core (
   input  logic                 clock,
   input  logic                 reset,
   input  nsls_pkg::cfg_type    cfg,
   input  logic                 step,
   input  logic [1:0]           mode,
   input  logic                 frame_count_enable,
   output nsls_pkg::result_type result
);

   nsls_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  line_index_ff, line_index_in;
   logic        second_pass_ff, second_pass_in;
   logic        burst_pending_ff, burst_pending_in;
   logic        compare_armed_ff, compare_armed_in;
   logic        lock_flag_ff, lock_flag_in;
   logic [15:0] shadow_width_ff, shadow_width_in;
   logic [15:0] shadow_period_ff, shadow_period_in;
   logic [7:0]  shadow_repeat_ff, shadow_repeat_in;
   logic        compare_hit;

   assign compare_hit = compare_armed_ff &&
                        (mode == nsls_pkg::MODE_LINE ||
                         (mode == nsls_pkg::MODE_BURST && nsls_pkg::COLOR_ENABLE));

   always_comb begin
      phase_in         = phase_ff;
      line_index_in    = line_index_ff;
      second_pass_in   = second_pass_ff;
      burst_pending_in = burst_pending_ff;
      compare_armed_in = compare_armed_ff;
      lock_flag_in     = lock_flag_ff;
      shadow_width_in  = shadow_width_ff;
      shadow_period_in = shadow_period_ff;
      shadow_repeat_in = shadow_repeat_ff;
      result           = '0;

      if (mode == nsls_pkg::MODE_UPDATE) begin
         case (phase_ff)
            nsls_pkg::PH_VERT: begin
               lock_flag_in       = 1'b0;
               compare_armed_in   = 1'b0;
               shadow_width_in    = cfg.vsync_width;
               result.frame_tick  = frame_count_enable;
               phase_in           = nsls_pkg::PH_EQ1;
            end
            nsls_pkg::PH_EQ1: begin
               shadow_width_in  = cfg.equalize_width;
               line_index_in    = '0;
               burst_pending_in = 1'b1;
               second_pass_in   = 1'b1;
               phase_in         = nsls_pkg::PH_PRE;
            end
            nsls_pkg::PH_PRE: begin
               shadow_width_in  = cfg.hsync_width;
               shadow_period_in = cfg.line_period;
               shadow_repeat_in = cfg.pre_active_repeat;
               phase_in         = nsls_pkg::PH_ACT;
            end
            nsls_pkg::PH_ACT: begin
               shadow_repeat_in = cfg.active_repeat & nsls_pkg::REPEAT_MASK;
               phase_in         = nsls_pkg::PH_EQ0;
            end
            default: begin
               // first equalize phase, also covers codes that cannot occur
               compare_armed_in = 1'b1;
               lock_flag_in     = 1'b1;
               shadow_width_in  = cfg.equalize_width;
               shadow_period_in = cfg.equalize_period;
               shadow_repeat_in = cfg.equalize_repeat;
               phase_in         = nsls_pkg::PH_VERT;
            end
         endcase
      end else if (compare_hit) begin
         result.serial_restart = 1'b1;
         if (nsls_pkg::COLOR_ENABLE && burst_pending_ff) begin
            burst_pending_in = 1'b0;
            // no burst ahead of row zero
            if (line_index_ff != '0) begin
               result.fetch_start      = 1'b1;
               result.fetch_from_burst = 1'b1;
               result.fetch_words      = nsls_pkg::BURST_WORD_COUNT;
            end
         end else begin
            burst_pending_in   = nsls_pkg::COLOR_ENABLE;
            result.fetch_start = 1'b1;
            result.fetch_line  = line_index_ff;
            result.fetch_words = nsls_pkg::ROW_WORD_COUNT;
            // show each row twice, advance after the second showing
            if (second_pass_ff) begin
               second_pass_in = 1'b0;
            end else begin
               if (line_index_ff < nsls_pkg::LINE_MAX) begin
                  line_index_in = line_index_ff + 8'd1;
               end
               second_pass_in = 1'b1;
            end
         end
      end

      result.sync_width   = shadow_width_in;
      result.period       = shadow_period_in;
      result.repeat_count = shadow_repeat_in;
      result.draw_lock    = lock_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= nsls_pkg::PH_VERT;
         line_index_ff    <= '0;
         second_pass_ff   <= 1'b0;
         burst_pending_ff <= 1'b0;
         compare_armed_ff <= 1'b0;
         lock_flag_ff     <= 1'b0;
         shadow_width_ff  <= '0;
         shadow_period_ff <= '0;
         shadow_repeat_ff <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         line_index_ff    <= line_index_in;
         second_pass_ff   <= second_pass_in;
         burst_pending_ff <= burst_pending_in;
         compare_armed_ff <= compare_armed_in;
         lock_flag_ff     <= lock_flag_in;
         shadow_width_ff  <= shadow_width_in;
         shadow_period_ff <= shadow_period_in;
         shadow_repeat_ff <= shadow_repeat_in;
      end
   end

endmodule

// File: hw/rtl/ntsc_sync_line_sequencer.sv
`timescale 1ns / 1ps
// An accepted event waits in the event register until the result register can
// take its result. Throughput: one event per cycle unless results stall; each
// register holds one beat, so a stalled result blocks only once both are full.
// Reset (synchronous, active high) clears the handshake flags, the configuration
// registers and the sequence state; the next update event runs the vertical phase.
// ----------------------------------------------------------------------------
// ntsc_sync_line_sequencer: composite sync line sequencer
// Event register, sequencing core and result register around one state step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntsc_sync_line_sequencer (
   input  logic        clock,
   input  logic        reset,
   nsls_req_if.sink    req_chan,
   nsls_rsp_if.source  rsp_chan,
   nsls_csr_if.sink    csr_chan
);

   nsls_pkg::cfg_type    cfg;
   nsls_pkg::result_type result;
   nsls_pkg::result_type rsp_data_ff;

   logic       ev_valid_ff, ev_valid_in;
   logic [1:0] ev_mode_ff;
   logic       ev_count_en_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       ev_advance;
   logic       req_take;

   nsls_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   nsls_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .step               (ev_advance),
      .mode               (ev_mode_ff),
      .frame_count_enable (ev_count_en_ff),
      .result             (result)
   );

   // advance the held event once the result register can take it
   assign ev_advance     = ev_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~ev_valid_ff | ev_advance;
   assign req_take       = req_chan.valid & req_chan.ready;
   assign ev_valid_in    = req_take | (ev_valid_ff & ~ev_advance);
   assign rsp_valid_in   = ev_advance | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ev_mode_ff     <= req_chan.mode;
         ev_count_en_ff <= req_chan.frame_count_enable;
      end
      if (ev_advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.sync_width       = rsp_data_ff.sync_width;
   assign rsp_chan.period           = rsp_data_ff.period;
   assign rsp_chan.repeat_count     = rsp_data_ff.repeat_count;
   assign rsp_chan.draw_lock        = rsp_data_ff.draw_lock;
   assign rsp_chan.frame_tick       = rsp_data_ff.frame_tick;
   assign rsp_chan.serial_restart   = rsp_data_ff.serial_restart;
   assign rsp_chan.fetch_start      = rsp_data_ff.fetch_start;
   assign rsp_chan.fetch_from_burst = rsp_data_ff.fetch_from_burst;
   assign rsp_chan.fetch_line       = rsp_data_ff.fetch_line;
   assign rsp_chan.fetch_words      = rsp_data_ff.fetch_words;

   `ASSERT_CLK(a_event_held, clock, reset, (ev_valid_ff && rsp_valid_ff && !rsp_chan.ready) |=> ev_valid_ff, "held event beat lost while result stalled")
   `ASSERT_CLK(a_tick_unlocked, clock, reset, (rsp_valid_ff && rsp_data_ff.frame_tick) |-> !rsp_data_ff.draw_lock, "frame tick with draw lock set")
   `ASSERT_CLK(a_words_start, clock, reset, rsp_valid_ff |-> ((rsp_data_ff.fetch_words != 8'd0) == rsp_data_ff.fetch_start), "fetch word count disagrees with fetch start")
   `ASSERT_CLK(a_start_restart, clock, reset, (rsp_valid_ff && rsp_data_ff.fetch_start) |-> rsp_data_ff.serial_restart, "fetch started without serializer restart")

endmodule

// File: tb/tb_ntsc_sync_line_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntsc_sync_line_sequencer: self-checking bench for the sync line sequencer
// Feeds timer events (updates, line and burst compares, unused codes) through
// the event channel and predicts each result beat from a local model of the
// five-phase frame sequence and the burst/row fetch alternation. Registers are
// rewritten between idle stretches. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb_ntsc_sync_line_sequencer;
   import nsls_pkg::*;

   localparam logic [1:0]  MODE_UNUSED  = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned ROUND_ITEMS  = 110;

   typedef struct packed {
      logic [1:0] mode;
      logic       count_en;
   } timer_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   nsls_req_if req_bus ();
   nsls_rsp_if rsp_bus ();
   nsls_csr_if csr_bus ();

   ntsc_sync_line_sequencer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Local copy of the sequencer state and registers
   cfg_type     regs            = '0;
   phase_type   seq_phase       = PH_VERT;
   logic [7:0]  row_index       = '0;
   logic        row_repeat_due  = 1'b0;
   logic        burst_due       = 1'b0;
   logic        compares_armed  = 1'b0;
   logic        draw_locked     = 1'b0;
   logic [15:0] next_width      = '0;
   logic [15:0] next_period     = '0;
   logic [7:0]  next_repeat     = '0;

   result_type      expected_results [$];
   timer_event_type pending_events   [$];
   int unsigned     events_queued    = 0;
   int unsigned     events_predicted = 0;
   int unsigned     error_count      = 0;

   // Stimulus planning: where the sequence will be once the queue has drained
   phase_type   plan_phase    = PH_VERT;
   logic        plan_armed    = 1'b0;
   int unsigned planned_items = 0;

   int unsigned req_gap     = 0;
   int unsigned req_steady  = 0;
   int unsigned rsp_stall   = 0;
   int unsigned rsp_steady  = 0;
   int unsigned quiet_cycles = 0;

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", what);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] seen);
      if (seen !== want)
         note_failure($sformatf("%s expected %0h, got %0h", name, want, seen));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] pick_value(input int unsigned bits);
      logic [15:0] top;
      int unsigned roll;
      top  = 16'((32'd1 << bits) - 1);
      roll = $urandom_range(0, 5);
      if (roll == 0) return '0;
      if (roll == 1) return top;
      return 16'($urandom) & top;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.equalize_width    = pick_value(16);
      c.vsync_width       = pick_value(16);
      c.hsync_width       = pick_value(16);
      c.equalize_period   = pick_value(16);
      c.line_period       = pick_value(16);
      c.equalize_repeat   = 8'(pick_value(8));
      c.pre_active_repeat = 8'(pick_value(8));
      c.active_repeat     = 8'(pick_value(8));
      return c;
   endfunction

   function automatic void apply_register(input csr_index_type idx, input logic [15:0] data);
      case (idx)
         CSR_EQUALIZE_WIDTH:    regs.equalize_width    = data;
         CSR_VSYNC_WIDTH:       regs.vsync_width       = data;
         CSR_HSYNC_WIDTH:       regs.hsync_width       = data;
         CSR_EQUALIZE_PERIOD:   regs.equalize_period   = data;
         CSR_LINE_PERIOD:       regs.line_period       = data;
         CSR_EQUALIZE_REPEAT:   regs.equalize_repeat   = data[7:0];
         CSR_PRE_ACTIVE_REPEAT: regs.pre_active_repeat = data[7:0];
         default:               regs.active_repeat     = data[7:0];
      endcase
   endfunction

   // Step the frame sequence or the fetch alternation and queue the result
   task automatic predict_event(input logic [1:0] mode, input logic count_en);
      result_type res;
      res = '0;
      if (mode == MODE_UPDATE) begin
         case (seq_phase)
            PH_VERT: begin
               draw_locked    = 1'b0;
               compares_armed = 1'b0;
               next_width     = regs.vsync_width;
               res.frame_tick = count_en;
               seq_phase      = PH_EQ1;
            end
            PH_EQ1: begin
               next_width     = regs.equalize_width;
               row_index      = '0;
               burst_due      = 1'b1;
               row_repeat_due = 1'b1;
               seq_phase      = PH_PRE;
            end
            PH_PRE: begin
               next_width  = regs.hsync_width;
               next_period = regs.line_period;
               next_repeat = regs.pre_active_repeat;
               seq_phase   = PH_ACT;
            end
            PH_ACT: begin
               next_repeat = regs.active_repeat & REPEAT_MASK;
               seq_phase   = PH_EQ0;
            end
            default: begin
               compares_armed = 1'b1;
               draw_locked    = 1'b1;
               next_width     = regs.equalize_width;
               next_period    = regs.equalize_period;
               next_repeat    = regs.equalize_repeat;
               seq_phase      = PH_VERT;
            end
         endcase
      end else if (compares_armed &&
                   (mode == MODE_LINE || (mode == MODE_BURST && COLOR_ENABLE))) begin
         res.serial_restart = 1'b1;
         if (COLOR_ENABLE && burst_due) begin
            burst_due = 1'b0;
            // no burst fetch on the first row
            if (row_index != 0) begin
               res.fetch_start      = 1'b1;
               res.fetch_from_burst = 1'b1;
               res.fetch_words      = BURST_WORD_COUNT;
            end
         end else begin
            burst_due       = COLOR_ENABLE;
            res.fetch_start = 1'b1;
            res.fetch_line  = row_index;
            res.fetch_words = ROW_WORD_COUNT;
            // each row goes out twice; hold the index at the last row
            if (row_repeat_due) begin
               row_repeat_due = 1'b0;
            end else begin
               if (row_index < LINE_MAX) row_index++;
               row_repeat_due = 1'b1;
            end
         end
      end
      res.sync_width   = next_width;
      res.period       = next_period;
      res.repeat_count = next_repeat;
      res.draw_lock    = draw_locked;
      expected_results.push_back(res);
      events_predicted++;
   endtask

   task automatic queue_event(input logic [1:0] mode, input logic count_en);
      timer_event_type ev;
      if (mode == MODE_UPDATE) begin
         planned_items++;
         case (plan_phase)
            PH_VERT: begin
               plan_armed = 1'b0;
               plan_phase = PH_EQ1;
            end
            PH_EQ1:  plan_phase = PH_PRE;
            PH_PRE:  plan_phase = PH_ACT;
            PH_ACT:  plan_phase = PH_EQ0;
            default: begin
               plan_armed = 1'b1;
               plan_phase = PH_VERT;
            end
         endcase
      end else if (plan_armed && mode != MODE_UNUSED) begin
         planned_items++;
      end
      ev.mode     = mode;
      ev.count_en = count_en;
      pending_events.push_back(ev);
      events_queued++;
   endtask

   // Event the block should ignore: unused code, or a compare while disarmed
   task automatic queue_stray();
      if (!plan_armed && coin())
         queue_event(coin() ? MODE_LINE : MODE_BURST, coin());
      else
         queue_event(MODE_UNUSED, coin());
   endtask

   // Walk the updates round to the armed window, then run compares in it
   task automatic queue_frame(input int unsigned lines, input bit allow_breaks);
      do begin
         if ($urandom_range(0, 7) == 0) queue_stray();
         queue_event(MODE_UPDATE, coin());
      end while (!plan_armed);
      for (int unsigned i = 0; i < lines; i++) begin
         if ($urandom_range(0, 15) == 0) queue_stray();
         if (allow_breaks && $urandom_range(0, 59) == 0) queue_event(MODE_UPDATE, coin());
         queue_event(coin() ? MODE_LINE : MODE_BURST, coin());
      end
   endtask

   function automatic int unsigned frame_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(40, 120);
      return $urandom_range(0, 24);
   endfunction

   task automatic load_config(input cfg_type c);
      logic [15:0] word [8];
      word[CSR_EQUALIZE_WIDTH]    = c.equalize_width;
      word[CSR_VSYNC_WIDTH]       = c.vsync_width;
      word[CSR_HSYNC_WIDTH]       = c.hsync_width;
      word[CSR_EQUALIZE_PERIOD]   = c.equalize_period;
      word[CSR_LINE_PERIOD]       = c.line_period;
      // upper byte of the 8-bit registers carries junk that must be dropped
      word[CSR_EQUALIZE_REPEAT]   = {8'($urandom), c.equalize_repeat};
      word[CSR_PRE_ACTIVE_REPEAT] = {8'($urandom), c.pre_active_repeat};
      word[CSR_ACTIVE_REPEAT]     = {8'($urandom), c.active_repeat};
      for (int i = 0; i < 8; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= csr_index_type'(i);
         csr_bus.data  <= word[i];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         apply_register(csr_index_type'(i), word[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic settle();
      while (events_predicted != events_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : event_driver
      timer_event_type ev;
      logic holding;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap       <= 0;
         req_steady    <= 0;
      end else begin
         holding = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predict_event(req_bus.mode, req_bus.frame_count_enable);
            holding = 1'b0;
         end
         if (!holding) begin
            if (req_gap != 0) begin
               req_bus.valid <= 1'b0;
               req_gap       <= req_gap - 1;
            end else if (pending_events.size() != 0) begin
               ev = pending_events.pop_front();
               req_bus.valid              <= 1'b1;
               req_bus.mode               <= ev.mode;
               req_bus.frame_count_enable <= ev.count_en;
               if (req_steady != 0) begin
                  req_steady <= req_steady - 1;
                  req_gap    <= 0;
               end else begin
                  req_gap <= draw_gap();
                  if ($urandom_range(0, 39) == 0) req_steady <= $urandom_range(20, 80);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      result_type seen, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall     <= 0;
         rsp_steady    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.sync_width, rsp_bus.period, rsp_bus.repeat_count,
                    rsp_bus.draw_lock, rsp_bus.frame_tick, rsp_bus.serial_restart,
                    rsp_bus.fetch_start, rsp_bus.fetch_from_burst, rsp_bus.fetch_line,
                    rsp_bus.fetch_words};
            if (expected_results.size() == 0) begin
               note_failure($sformatf("result beat with nothing expected (%h)", seen));
            end else begin
               want = expected_results.pop_front();
               check_field("sync_width", want.sync_width, seen.sync_width);
               check_field("period", want.period, seen.period);
               check_field("repeat_count", want.repeat_count, seen.repeat_count);
               check_field("draw_lock", want.draw_lock, seen.draw_lock);
               check_field("frame_tick", want.frame_tick, seen.frame_tick);
               check_field("serial_restart", want.serial_restart, seen.serial_restart);
               check_field("fetch_start", want.fetch_start, seen.fetch_start);
               check_field("fetch_from_burst", want.fetch_from_burst, seen.fetch_from_burst);
               check_field("fetch_line", want.fetch_line, seen.fetch_line);
               check_field("fetch_words", want.fetch_words, seen.fetch_words);
            end
         end
         if (rsp_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall     <= rsp_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_steady != 0)
               rsp_steady <= rsp_steady - 1;
            else if ($urandom_range(0, 49) == 0)
               rsp_steady <= $urandom_range(30, 120);
            else if ($urandom_range(0, 3) == 0)
               rsp_stall <= draw_gap();
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      cfg_type     widest;
      int unsigned goal;
      req_bus.valid              = 1'b0;
      req_bus.mode               = MODE_UPDATE;
      req_bus.frame_count_enable = 1'b0;
      rsp_bus.ready              = 1'b0;
      csr_bus.valid              = 1'b0;
      csr_bus.index              = CSR_EQUALIZE_WIDTH;
      csr_bus.data               = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      widest = '1;
      load_config(widest);

      // disarmed at reset: unused code and compares change nothing
      queue_event(MODE_UNUSED, 1'b1);
      queue_event(MODE_LINE, 1'b1);
      queue_event(MODE_BURST, 1'b0);
      // full sequence: vertical with frame tick, equalize, pre-active, active, arm
      queue_event(MODE_UPDATE, 1'b1);
      queue_event(MODE_UPDATE, 1'b0);
      queue_event(MODE_UPDATE, 1'b1);
      queue_event(MODE_UPDATE, 1'b0);
      queue_event(MODE_UPDATE, 1'b1);
      // burst on row zero, both compare kinds, row shown twice then advanced
      queue_event(MODE_BURST, 1'b0);
      queue_event(MODE_LINE, 1'b1);
      queue_event(MODE_LINE, 1'b0);
      queue_event(MODE_BURST, 1'b1);
      queue_event(MODE_BURST, 1'b0);
      queue_event(MODE_LINE, 1'b1);
      queue_event(MODE_UNUSED, 1'b0);
      queue_event(MODE_LINE, 1'b0);
      queue_event(MODE_LINE, 1'b1);
      // vertical without counting disarms; compare after it is dropped
      queue_event(MODE_UPDATE, 1'b0);
      queue_event(MODE_LINE, 1'b1);
      queue_event(MODE_UPDATE, 1'b1);
      settle();

      planned_items = 0;
      for (int round = 0; round < 5; round++) begin
         if (round == 0) load_config('0);
         else load_config(random_config());
         goal = planned_items + ROUND_ITEMS;
         while (planned_items < goal) queue_frame(frame_length(), 1'b1);
         settle();
      end

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
